// ----- hw/rtl/vgsf_pkg.sv -----
// Shared types, codes and defaults for the gate scan framebuffer.
package vgsf_pkg;

  localparam int PLANE_BYTES_DEF = 552;
  localparam int GATE_LAST_DEF   = 43;

  typedef enum logic [1:0] {
    ACT_DRAW = 2'd0,
    ACT_FILL = 2'd1,
    ACT_SWAP = 2'd2,
    ACT_TICK = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_FILL,
    ST_TICK
  } state_t;

  typedef enum logic [1:0] {
    WR_CLEAR,
    WR_FILL,
    WR_DRAW
  } wr_src_t;

  typedef struct packed {
    logic    capture;
    logic    swap;
    logic    cnt_clr;
    logic    cnt_adv;
    logic    tick_mode;
    logic    sw_clr;
    logic    sw_adv;
    logic    wr_en;
    wr_src_t wr_src;
    logic    out_load;
    logic    gate_step;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic fill_last;
    logic draw_last;
    logic tick_last;
    logic out_free;
  } stat_t;

endpackage

// ----- hw/rtl/vfd_gate_scan_framebuffer.sv -----
// Draw: read and write back six bytes. Fill: write 2*PLANE_BYTES bytes of the back buffer.
// Swap: taken in the idle state without leaving it. Tick: 60 bytes at one per cycle from the frame memory's
// prefetched read port, slower under backpressure; the first byte follows the tick state and the output register.
// Items are processed one at a time; a tick's last byte may wait while the next item is taken.
// After reset all 4*PLANE_BYTES bytes of the frame memory (2208 by default) are cleared one byte
// per cycle, with in_ready low.
module vfd_gate_scan_framebuffer
  import vgsf_pkg::*;
#(
  parameter int PLANE_BYTES = PLANE_BYTES_DEF,
  parameter int GATE_LAST   = GATE_LAST_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [6:0] in_pixel_x,
  input  logic [4:0] in_pixel_y,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_shift_byte,
  output logic       out_plane,
  output logic       out_latch,
  output logic       out_last
);

  cmd_t  cmd;
  stat_t stat;

  vgsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  vgsf_dpath #(
    .PLANE_BYTES (PLANE_BYTES),
    .GATE_LAST   (GATE_LAST)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_value       (in_value),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_shift_byte (out_shift_byte),
    .out_plane      (out_plane),
    .out_latch      (out_latch),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  a_last_on_plane1_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_latch && out_plane))
    else $error("last result not on final latch byte of plane 1");

  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_action != ACT_SWAP)) |=> !in_ready)
    else $error("input taken while a draw, fill or tick is in progress");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !in_ready)
    else $error("frame memory written while idle");

  a_load_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!in_ready && stat.out_free))
    else $error("output loaded outside a tick or over a pending transaction");
`endif

endmodule

// ----- hw/rtl/vgsf_ctrl.sv -----
// Controller state machine: sequences clear, draw, fill, swap and tick.
module vgsf_ctrl
  import vgsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  input  stat_t      stat,
  output logic       in_ready,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (action_t'(in_action))
            ACT_DRAW: state_nxt = ST_DRAW_RD;
            ACT_FILL: state_nxt = ST_FILL;
            ACT_SWAP: state_nxt = ST_IDLE;
            ACT_TICK: state_nxt = ST_TICK;
          endcase
        end
      end
      ST_DRAW_RD: state_nxt = ST_DRAW_WR;
      ST_DRAW_WR: begin
        if (stat.draw_last) state_nxt = ST_IDLE;
        else state_nxt = ST_DRAW_RD;
      end
      ST_FILL: begin
        if (stat.fill_last) state_nxt = ST_IDLE;
      end
      ST_TICK: begin
        if (stat.out_free && stat.tick_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.tick_mode = 1'b1;
    cmd.wr_src    = WR_CLEAR;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_CLEAR;
        cmd.sw_adv = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          unique case (action_t'(in_action))
            ACT_DRAW: cmd.cnt_clr = 1'b1;
            ACT_FILL: cmd.sw_clr  = 1'b1;
            ACT_SWAP: cmd.swap    = 1'b1;
            ACT_TICK: cmd.cnt_clr = 1'b1;
          endcase
        end
      end
      ST_DRAW_RD: begin
        cmd.tick_mode = 1'b0;
      end
      ST_DRAW_WR: begin
        cmd.tick_mode = 1'b0;
        cmd.wr_en     = 1'b1;
        cmd.wr_src    = WR_DRAW;
        cmd.cnt_adv   = 1'b1;
      end
      ST_FILL: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_FILL;
        cmd.sw_adv = 1'b1;
      end
      ST_TICK: begin
        // advance one byte each time the output register frees up
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.cnt_adv   = 1'b1;
          cmd.gate_step = stat.tick_last;
        end
      end
      default: begin
        cmd.tick_mode = 1'b1;
      end
    endcase
  end

endmodule

// ----- hw/rtl/vgsf_dpath.sv -----
// Datapath: frame memory, address generation, gate pattern and output register.
module vgsf_dpath
  import vgsf_pkg::*;
#(
  parameter int PLANE_BYTES = PLANE_BYTES_DEF,
  parameter int GATE_LAST   = GATE_LAST_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output stat_t      stat,
  input  logic [6:0] in_pixel_x,
  input  logic [4:0] in_pixel_y,
  input  logic [7:0] in_value,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_shift_byte,
  output logic       out_plane,
  output logic       out_latch,
  output logic       out_last
);

  localparam int MEM_DEPTH = 4 * PLANE_BYTES;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int OW        = $clog2(PLANE_BYTES) + 1;

  localparam logic [AW-1:0] PLANE_SPAN = AW'(PLANE_BYTES);
  localparam logic [AW-1:0] BUF_SPAN   = AW'(2 * PLANE_BYTES);
  localparam logic [AW-1:0] CLEAR_END  = AW'(MEM_DEPTH - 1);
  localparam logic [AW-1:0] FILL_END   = AW'(2 * PLANE_BYTES - 1);
  localparam logic [OW-1:0] PLANE_OFF  = OW'(PLANE_BYTES);
  localparam logic [5:0]    GATE_END   = 6'(GATE_LAST);

  localparam logic [12:0] DIV6_RECIP    = 13'd43;  // floor(x*43/256) == x/6 for x < 128
  localparam logic [4:0]  DRAW_COL_LAST = 5'd2;
  localparam logic [4:0]  TICK_COL_LAST = 5'd29;
  localparam logic [4:0]  DATA_BYTES    = 5'd24;
  localparam logic [7:0]  MASK_ODD      = 8'h55;
  localparam logic [7:0]  MASK_EVEN     = 8'hAA;
  localparam logic [63:0] PAT_FIRST     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PAT_SECOND    = 64'hC000_0000_0000_0000;

  function automatic logic [5:0] pix_pattern(input logic [2:0] rem);
    logic [5:0] pat;
    unique case (rem)
      3'd0:    pat = 6'b100000;
      3'd1:    pat = 6'b001000;
      3'd2:    pat = 6'b000010;
      3'd3:    pat = 6'b000001;
      3'd4:    pat = 6'b000100;
      3'd5:    pat = 6'b010000;
      default: pat = 6'b000000;
    endcase
    return pat;
  endfunction

  function automatic logic [OW-1:0] wrap_off(input logic [OW-1:0] off);
    return (off >= PLANE_OFF) ? (off - PLANE_OFF) : off;
  endfunction

  function automatic logic [AW-1:0] mk_addr(input logic bsel, input logic pl,
                                            input logic [OW-1:0] off);
    logic [AW-1:0] a;
    a = (bsel ? BUF_SPAN : '0) + (pl ? PLANE_SPAN : '0) + AW'(off);
    return a;
  endfunction

  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    rd_data_r;

  logic          back_sel_r;
  logic [5:0]    gate_cnt_r;
  logic [63:0]   gate_pat_r;
  logic [AW-1:0] sw_r, sw_nxt;
  logic          plane_r, plane_nxt;
  logic [4:0]    col_r, col_nxt;
  logic [OW-1:0] base_r;
  logic [23:0]   word_r;
  logic [7:0]    value_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_plane_r;
  logic          out_latch_r;
  logic          out_last_r;

  // draw address and bit word from the incoming pixel
  logic [12:0]   div_prod;
  logic [4:0]    col_q;
  logic [6:0]    rem_full;
  logic [4:0]    gcol;
  logic [OW-1:0] draw_base;
  logic [5:0]    pat;
  logic [23:0]   draw_word;

  always_comb begin
    div_prod  = {6'd0, in_pixel_x} * DIV6_RECIP;
    col_q     = div_prod[12:8];
    rem_full  = in_pixel_x - 7'({2'd0, col_q} * 7'd6);
    gcol      = col_q + 5'd1;
    draw_base = OW'({gcol, 4'd0}) + OW'({gcol, 3'd0})
              + OW'({in_pixel_y[4:2], 1'b0}) + OW'(in_pixel_y[4:2]);
    pat       = pix_pattern(rem_full[2:0]);
    unique case (in_pixel_y[1:0])
      2'd0: draw_word = {pat, 18'd0};
      2'd1: draw_word = {6'd0, pat, 12'd0};
      2'd2: draw_word = {12'd0, pat, 6'd0};
      2'd3: draw_word = {18'd0, pat};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      base_r  <= draw_base;
      word_r  <= draw_word;
      value_r <= in_value;
    end
  end

  // byte counters: plane and column within the current operation
  logic [4:0] col_end;

  always_comb begin
    col_end   = cmd.tick_mode ? TICK_COL_LAST : DRAW_COL_LAST;
    plane_nxt = plane_r;
    col_nxt   = col_r;
    if (cmd.cnt_clr) begin
      plane_nxt = 1'b0;
      col_nxt   = '0;
    end else if (cmd.cnt_adv) begin
      if (col_r == col_end) begin
        col_nxt   = '0;
        plane_nxt = ~plane_r;
      end else begin
        col_nxt = col_r + 5'd1;
      end
    end
    sw_nxt = sw_r;
    if (cmd.sw_clr) sw_nxt = '0;
    else if (cmd.sw_adv) sw_nxt = sw_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= 1'b0;
      col_r   <= '0;
      sw_r    <= '0;
    end else begin
      plane_r <= plane_nxt;
      col_r   <= col_nxt;
      sw_r    <= sw_nxt;
    end
  end

  // read address: tick prefetches the next byte, draw reads the current one
  logic [OW-1:0] tick_start;
  logic [OW-1:0] tick_off;
  logic [OW-1:0] draw_off;
  logic [AW-1:0] draw_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    draw_byte;

  always_comb begin
    tick_start = OW'({gate_cnt_r[5:1], 4'd0}) + OW'({gate_cnt_r[5:1], 3'd0});
    tick_off   = wrap_off(tick_start + OW'(col_nxt));
    draw_off   = wrap_off(base_r + OW'(col_r));
    draw_addr  = mk_addr(back_sel_r, plane_r, draw_off);
    rd_addr    = cmd.tick_mode ? mk_addr(~back_sel_r, plane_nxt, tick_off) : draw_addr;

    unique case (col_r[1:0])
      2'd0:    draw_byte = word_r[23:16];
      2'd1:    draw_byte = word_r[15:8];
      2'd2:    draw_byte = word_r[7:0];
      default: draw_byte = 8'd0;
    endcase
    if (!value_r[plane_r]) draw_byte = 8'd0;

    unique case (cmd.wr_src)
      WR_CLEAR: begin
        wr_addr = sw_r;
        wr_data = 8'd0;
      end
      WR_FILL: begin
        wr_addr = (back_sel_r ? BUF_SPAN : '0) + sw_r;
        wr_data = value_r;
      end
      WR_DRAW: begin
        wr_addr = draw_addr;
        wr_data = rd_data_r | draw_byte;
      end
      default: begin
        wr_addr = sw_r;
        wr_data = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // output byte selection
  logic [7:0] mask;
  logic [2:0] gate_idx;
  logic [4:0] gate_col;
  logic [7:0] gate_byte;
  logic [7:0] out_byte_nxt;

  always_comb begin
    mask     = gate_cnt_r[0] ? MASK_ODD : MASK_EVEN;
    gate_col = col_r - DATA_BYTES;
    gate_idx = gate_col[2:0];
    unique case (gate_idx)
      3'd0:    gate_byte = gate_pat_r[63:56];
      3'd1:    gate_byte = gate_pat_r[55:48];
      3'd2:    gate_byte = gate_pat_r[47:40];
      3'd3:    gate_byte = gate_pat_r[39:32];
      3'd4:    gate_byte = gate_pat_r[31:24];
      3'd5:    gate_byte = gate_pat_r[23:16];
      default: gate_byte = 8'd0;
    endcase
    out_byte_nxt = (col_r < DATA_BYTES) ? (rd_data_r & mask) : gate_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte_r  <= out_byte_nxt;
      out_plane_r <= plane_r;
      out_latch_r <= (col_r == TICK_COL_LAST);
      out_last_r  <= plane_r && (col_r == TICK_COL_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // gate stepping and buffer select
  logic [5:0]  gate_base;
  logic [63:0] gate_pat_step;

  always_comb begin
    gate_base = (gate_cnt_r > GATE_END) ? 6'd0 : gate_cnt_r;
    if (gate_base == 6'd0) gate_pat_step = PAT_FIRST;
    else if (gate_base == 6'd1) gate_pat_step = PAT_SECOND;
    else gate_pat_step = gate_pat_r >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      back_sel_r <= 1'b0;
      gate_cnt_r <= '0;
      gate_pat_r <= '0;
    end else begin
      if (cmd.swap) back_sel_r <= ~back_sel_r;
      if (cmd.gate_step) begin
        gate_pat_r <= gate_pat_step;
        gate_cnt_r <= gate_base + 6'd1;
      end
    end
  end

  assign stat.clear_last = (sw_r == CLEAR_END);
  assign stat.fill_last  = (sw_r == FILL_END);
  assign stat.draw_last  = plane_r && (col_r == DRAW_COL_LAST);
  assign stat.tick_last  = plane_r && (col_r == TICK_COL_LAST);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_shift_byte = out_byte_r;
  assign out_plane      = out_plane_r;
  assign out_latch      = out_latch_r;
  assign out_last       = out_last_r;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the gate scan framebuffer: directed table, then random actions.
`timescale 1ns / 1ps

module tb;
  import vgsf_pkg::*;

  localparam int PB           = PLANE_BYTES_DEF;
  localparam int GATE_END     = GATE_LAST_DEF;
  localparam int RAND_ITEMS   = 480;
  localparam int QUIET_FROM   = 430;
  localparam int DRAIN_AT     = 240;
  localparam int STALL_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 100;
  localparam int DIR_ROWS     = 23;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_action = ACT_DRAW;
  logic [6:0] in_pixel_x = '0;
  logic [4:0] in_pixel_y = '0;
  logic [7:0] in_value = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_shift_byte;
  logic       out_plane;
  logic       out_latch;
  logic       out_last;

  typedef struct packed {
    logic [7:0] shift_byte;
    logic       plane;
    logic       latch;
    logic       last;
  } scan_beat_t;

  typedef struct packed {
    action_t    act;
    logic [6:0] x;
    logic [4:0] y;
    logic [7:0] value;
    logic       typed;   // data bytes of a tick are given here, not predicted
    logic [7:0] data;
  } stim_row_t;

  // Framebuffer and scan state as the block should hold it
  logic [7:0]  fb_mem [0:4*PB-1];
  logic        back_sel;
  logic [5:0]  gate_cnt;
  logic [63:0] gate_pat;
  scan_beat_t  pending_beats [$];

  int err_cnt = 0;
  int idle_cycles = 0;
  int rdy_hold = 0;
  bit quiet = 1'b0;

  stim_row_t dir_table [DIR_ROWS] = '{
    '{ACT_TICK, 7'd0,   5'd0,  8'h00, 1'b1, 8'h00},  // front buffer still clear
    '{ACT_FILL, 7'd0,   5'd0,  8'hFF, 1'b0, 8'h00},
    '{ACT_SWAP, 7'd0,   5'd0,  8'h00, 1'b0, 8'h00},
    '{ACT_TICK, 7'd0,   5'd0,  8'h00, 1'b1, 8'h55},  // odd gate
    '{ACT_TICK, 7'd0,   5'd0,  8'h00, 1'b1, 8'hAA},  // even gate
    '{ACT_FILL, 7'd0,   5'd0,  8'h00, 1'b0, 8'h00},
    '{ACT_DRAW, 7'd0,   5'd0,  8'h03, 1'b0, 8'h00},
    '{ACT_DRAW, 7'd127, 5'd31, 8'h03, 1'b0, 8'h00},  // last byte of a plane
    '{ACT_DRAW, 7'd1,   5'd5,  8'h01, 1'b0, 8'h00},
    '{ACT_DRAW, 7'd2,   5'd10, 8'h02, 1'b0, 8'h00},
    '{ACT_DRAW, 7'd3,   5'd15, 8'hFF, 1'b0, 8'h00},
    '{ACT_DRAW, 7'd4,   5'd16, 8'hFC, 1'b0, 8'h00},  // no plane selected
    '{ACT_DRAW, 7'd5,   5'd27, 8'h03, 1'b0, 8'h00},
    '{ACT_DRAW, 7'd6,   5'd0,  8'h01, 1'b0, 8'h00},
    '{ACT_DRAW, 7'd126, 5'd30, 8'h02, 1'b0, 8'h00},
    '{ACT_SWAP, 7'd0,   5'd0,  8'h00, 1'b0, 8'h00},
    '{ACT_TICK, 7'd0,   5'd0,  8'h00, 1'b0, 8'h00},
    '{ACT_TICK, 7'd0,   5'd0,  8'h00, 1'b0, 8'h00},
    '{ACT_TICK, 7'd0,   5'd0,  8'h00, 1'b0, 8'h00},
    '{ACT_FILL, 7'd0,   5'd0,  8'hA5, 1'b0, 8'h00},
    '{ACT_SWAP, 7'd0,   5'd0,  8'h00, 1'b0, 8'h00},
    '{ACT_TICK, 7'd0,   5'd0,  8'h00, 1'b1, 8'hA0},
    '{ACT_TICK, 7'd0,   5'd0,  8'h00, 1'b1, 8'h05}
  };

  vfd_gate_scan_framebuffer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_shift_byte (out_shift_byte),
    .out_plane      (out_plane),
    .out_latch      (out_latch),
    .out_last       (out_last)
  );

  always #1 clk = ~clk;

  function automatic logic [5:0] pix_bits(input int col);
    case (col)
      0: pix_bits = 6'b100000;
      1: pix_bits = 6'b001000;
      2: pix_bits = 6'b000010;
      3: pix_bits = 6'b000001;
      4: pix_bits = 6'b000100;
      default: pix_bits = 6'b010000;
    endcase
  endfunction

  function automatic int mem_addr(input logic buf_sel, input logic pl, input int off);
    int base;
    base = buf_sel ? 2 * PB : 0;
    mem_addr = base + (pl ? PB : 0) + (off % PB);
  endfunction

  // Update the framebuffer model for one action and queue the bytes a tick shifts out
  task automatic model_action(input action_t act, input logic [6:0] x, input logic [4:0] y,
                              input logic [7:0] value, input logic typed,
                              input logic [7:0] data);
    int         base;
    int         g;
    int         a;
    logic [23:0] word;
    logic [7:0]  mask;
    logic        front;
    scan_beat_t  beat;
    case (act)
      ACT_DRAW: begin
        base = 24 * (int'(x) / 6 + 1) + 3 * (int'(y) / 4);
        word = 24'(pix_bits(int'(x) % 6)) << (18 - 6 * (int'(y) % 4));
        for (int pl = 0; pl < 2; pl++) begin
          if (value[pl]) begin
            for (int k = 0; k < 3; k++) begin
              a = mem_addr(back_sel, pl[0], base + k);
              fb_mem[a] = fb_mem[a] | 8'(word >> (16 - 8 * k));
            end
          end
        end
      end
      ACT_FILL: begin
        base = back_sel ? 2 * PB : 0;
        for (int i = 0; i < 2 * PB; i++) fb_mem[base + i] = value;
      end
      ACT_SWAP: back_sel = ~back_sel;
      default: begin
        front = ~back_sel;
        mask  = gate_cnt[0] ? 8'h55 : 8'hAA;
        base  = 24 * (int'(gate_cnt) / 2);
        for (int pl = 0; pl < 2; pl++) begin
          for (int i = 0; i < 30; i++) begin
            if (i < 24)
              beat.shift_byte = typed ? data : (fb_mem[mem_addr(front, pl[0], base + i)] & mask);
            else
              beat.shift_byte = gate_pat[63 - 8 * (i - 24) -: 8];
            beat.plane = pl[0];
            beat.latch = (i == 29);
            beat.last  = (pl == 1) && (i == 29);
            pending_beats.push_back(beat);
          end
        end
        // advance the gate window
        g = int'(gate_cnt);
        if (g > GATE_END) g = 0;
        if (g == 0)
          gate_pat = 64'h8000_0000_0000_0000;
        else if (g == 1)
          gate_pat = 64'hC000_0000_0000_0000;
        else
          gate_pat = gate_pat >> 1;
        gate_cnt = 6'(g + 1);
      end
    endcase
  endtask

  task automatic send_action(input action_t act, input logic [6:0] x, input logic [4:0] y,
                             input logic [7:0] value, input logic typed,
                             input logic [7:0] data);
    @(negedge clk);
    in_valid   <= 1'b1;
    in_action  <= act;
    in_pixel_x <= x;
    in_pixel_y <= y;
    in_value   <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_action(act, x, y, value, typed, data);
  endtask

  task automatic sender_gap(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(posedge clk);
  endtask

  task automatic drain_results();
    sender_gap(1);
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls in bursts, with longer ready stretches in between
  always @(negedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
      rdy_hold = 0;
    end else if (rdy_hold != 0) begin
      rdy_hold--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rdy_hold = $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
      rdy_hold = $urandom_range(0, 19);
    end
  end

  always @(posedge clk) begin
    scan_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected transaction: shift_byte %02h", out_shift_byte);
        err_cnt++;
      end else begin
        want = pending_beats.pop_front();
        if (out_shift_byte !== want.shift_byte) begin
          $error("shift_byte: expected %02h, actual %02h", want.shift_byte, out_shift_byte);
          err_cnt++;
        end
        if (out_plane !== want.plane) begin
          $error("plane: expected %0d, actual %0d", want.plane, out_plane);
          err_cnt++;
        end
        if (out_latch !== want.latch) begin
          $error("latch: expected %0d, actual %0d", want.latch, out_latch);
          err_cnt++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: covers the clear pass after reset and the longest fill
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL vfd_gate_scan_framebuffer");
      $finish;
    end
  end

  initial begin
    int         r;
    action_t    act;
    logic [7:0] value;
    for (int i = 0; i < 4 * PB; i++) fb_mem[i] = 8'h00;
    back_sel = 1'b0;
    gate_cnt = '0;
    gate_pat = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_action(dir_table[i].act, dir_table[i].x, dir_table[i].y, dir_table[i].value,
                  dir_table[i].typed, dir_table[i].data);
    drain_results();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == DRAIN_AT) drain_results();
      if (n == QUIET_FROM) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 9));
      r = $urandom_range(0, 99);
      if (r < 55)
        act = ACT_DRAW;
      else if (r < 80)
        act = ACT_TICK;
      else if (r < 92)
        act = ACT_SWAP;
      else
        act = ACT_FILL;
      value = 8'($urandom_range(0, 255));
      // keep most fills blank so drawn pixels stay visible
      if (act == ACT_FILL && $urandom_range(0, 1) == 0) value = 8'h00;
      send_action(act, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)), value,
                  1'b0, 8'h00);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("PASS vfd_gate_scan_framebuffer");
    else
      $display("FAIL vfd_gate_scan_framebuffer");
    $finish;
  end

endmodule
